// ===== src/tees_pkg.sv =====
package tees_pkg;

   // Item codes handed from the front to the back
   typedef enum logic [1:0] {
      CMD_PLAIN,
      CMD_ESCAPE,
      CMD_TAB,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic       list_mode;
      logic [5:0] tab_width;
      logic [7:0] fill_char;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ESC_HI,
      BK_ESC_LO,
      BK_FILL
   } back_state_type;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_LIST_MODE = 2'd0;
   localparam logic [1:0] REG_TAB_WIDTH = 2'd1;
   localparam logic [1:0] REG_FILL_CHAR = 2'd2;

   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;

   localparam logic [5:0] TabWidthReset = 6'd8;
   localparam logic [7:0] FillCharReset = 8'd1;
   localparam logic [5:0] TabWidthMax   = 6'd32;

   localparam logic [6:0] LowSevenMask = 7'o177;
   localparam logic [6:0] TabCode      = 7'd9;
   localparam logic [7:0] CtrlLimit    = 8'd32;
   localparam logic [7:0] Backslash    = 8'h5C;
   localparam logic [7:0] AsciiZero    = 8'h30;
   localparam logic [2:0] OctalMask    = 3'o7;

   // Command queue: depth must stay a power of two
   localparam int QueueDepth = 2;
   localparam int QueueIdxW  = 1;
   localparam int QueueCntW  = 2;

   // Result packing: char_out, column_count, overflow, zero pad
   localparam int CountW   = 11;
   localparam int RspDataW = 24;
   localparam int RspPadW  = RspDataW - 8 - CountW - 1;

endpackage

// ===== src/tees_front.sv =====
module tees_front (
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  tees_pkg::cfg_type cfg,
   output logic           push_valid,
   input  logic           push_ready,
   output tees_pkg::cmd_type push_cmd
);
   import tees_pkg::*;

   logic [6:0] low7;

   assign low7       = req_tdata[6:0] & LowSevenMask;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_cmd.ch = req_tdata;
      if (low7 == 7'd0) begin
         push_cmd.kind = CMD_END;
      end else if (cfg.list_mode) begin
         push_cmd.kind = (req_tdata < CtrlLimit) ? CMD_ESCAPE : CMD_PLAIN;
      end else if (low7 == TabCode) begin
         push_cmd.kind = CMD_TAB;
      end else begin
         push_cmd.kind = CMD_PLAIN;
      end
   end

endmodule

// ===== src/tees_cmd_queue.sv =====
module tees_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tees_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tees_pkg::cmd_type pop_cmd
);
   import tees_pkg::*;

   cmd_type              slot_ff [QueueDepth];
   logic [QueueIdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/tees_back.sv =====
module tees_back #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tees_pkg::cfg_type             cfg,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  tees_pkg::cmd_type             q_cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tees_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import tees_pkg::*;

   localparam int ColW = $clog2(MAX_COLUMNS + 1);
   localparam int ExtW = ColW + CountW;
   localparam logic [ColW-1:0] ColMax = ColW'(MAX_COLUMNS);

   back_state_type      state_ff, state_in;
   logic [ColW-1:0]     column_ff, column_in;
   logic [4:0]          phase_ff, phase_in;
   logic                sat_ff, sat_in;
   logic [7:0]          ch_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                emit, advance, line_done, pop;
   logic [7:0]          out_byte;
   logic [5:0]          eff_width, phase_inc;
   logic [4:0]          phase_next;
   logic [ExtW-1:0]     column_ext;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_ready    = pop;
   assign column_ext = ExtW'(column_ff);

   always_comb begin
      if (cfg.tab_width == 6'd0) begin
         eff_width = 6'd1;
      end else if (cfg.tab_width > TabWidthMax) begin
         eff_width = TabWidthMax;
      end else begin
         eff_width = cfg.tab_width;
      end
      phase_inc  = {1'b0, phase_ff} + 6'd1;
      phase_next = (phase_inc >= eff_width) ? 5'd0 : phase_inc[4:0];
   end

   always_comb begin
      state_in  = state_ff;
      emit      = 1'b0;
      advance   = 1'b0;
      line_done = 1'b0;
      pop       = 1'b0;
      out_byte  = q_cmd.ch;
      case (state_ff)
         BK_IDLE: begin
            if (out_free && q_valid) begin
               pop  = 1'b1;
               emit = 1'b1;
               case (q_cmd.kind)
                  CMD_END: begin
                     line_done = 1'b1;
                  end
                  CMD_ESCAPE: begin
                     out_byte = Backslash;
                     advance  = 1'b1;
                     state_in = BK_ESC_HI;
                  end
                  CMD_TAB: begin
                     advance = 1'b1;
                     if (phase_next != 5'd0) begin
                        state_in = BK_FILL;
                     end
                  end
                  default: begin
                     advance = 1'b1;
                  end
               endcase
            end
         end
         BK_ESC_HI: begin
            out_byte = AsciiZero + {3'b000, ch_ff[7:3]};
            if (out_free) begin
               emit     = 1'b1;
               advance  = 1'b1;
               state_in = BK_ESC_LO;
            end
         end
         BK_ESC_LO: begin
            out_byte = AsciiZero + {5'b00000, ch_ff[2:0] & OctalMask};
            if (out_free) begin
               emit     = 1'b1;
               advance  = 1'b1;
               state_in = BK_IDLE;
            end
         end
         BK_FILL: begin
            out_byte = cfg.fill_char;
            if (out_free) begin
               emit    = 1'b1;
               advance = 1'b1;
               if (phase_next == 5'd0) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Line state: saturate the column, wrap the phase, clear on the terminator
   always_comb begin
      column_in = column_ff;
      phase_in  = phase_ff;
      sat_in    = sat_ff;
      if (line_done) begin
         column_in = '0;
         phase_in  = '0;
         sat_in    = 1'b0;
      end else if (advance) begin
         phase_in = phase_next;
         if (column_ff >= ColMax) begin
            column_in = ColMax;
            sat_in    = 1'b1;
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = line_done;
         if (line_done) begin
            rsp_data_in = {{RspPadW{1'b0}}, sat_ff, column_ext[CountW-1:0], out_byte};
         end else begin
            rsp_data_in = {{RspPadW{1'b0}}, 1'b0, {CountW{1'b0}}, out_byte};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         column_ff    <= '0;
         phase_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         phase_ff     <= phase_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ch_ff <= q_cmd.ch;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/tab_expand_escape_stream.sv =====
// Expands a byte stream line by line. Each request is one source byte; results are
// output bytes, one per cycle at most. An ordinary byte gives one byte, an escaped
// control byte in list mode three bytes (backslash and two octal digits), and a tab
// in normal mode the tab byte plus one fill byte per column up to the next tab stop (at
// most 32 bytes, as the tab stop is held to 1..32 columns). The back-end sequencer,
// which owns the column and phase state and emits through a single output register,
// produces these bytes; a two-entry command queue lets the input keep flowing while it
// works. A byte with its low seven bits clear ends the line and carries the line
// length (saturating at MAX_COLUMNS, with the overflow flag) in its result. Write
// configuration only while the block is idle.
module tab_expand_escape_stream #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] char_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] char_out, [18:8] column_count, [19] overflow, [23:20] zero
   output logic [tees_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tlast,  // line_end
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tees_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [tees_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [tees_pkg::CsrDataW-1:0] csr_prdata,
   output logic                          csr_pready
);
   import tees_pkg::*;

   logic       list_mode_ff, list_mode_in;
   logic [5:0] tab_width_ff, tab_width_in;
   logic [7:0] fill_char_ff, fill_char_in;
   logic       csr_write;
   logic [1:0] csr_index;
   cfg_type    cfg;

   logic       push_valid, push_ready;
   cmd_type    push_cmd;
   logic       q_valid, q_ready;
   cmd_type    q_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      list_mode_in = list_mode_ff;
      tab_width_in = tab_width_ff;
      fill_char_in = fill_char_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LIST_MODE: list_mode_in = csr_pwdata[0];
            REG_TAB_WIDTH: tab_width_in = csr_pwdata[5:0];
            REG_FILL_CHAR: fill_char_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LIST_MODE: csr_prdata = CsrDataW'(list_mode_ff);
         REG_TAB_WIDTH: csr_prdata = CsrDataW'(tab_width_ff);
         REG_FILL_CHAR: csr_prdata = CsrDataW'(fill_char_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_mode_ff <= 1'b0;
         tab_width_ff <= TabWidthReset;
         fill_char_ff <= FillCharReset;
      end else begin
         list_mode_ff <= list_mode_in;
         tab_width_ff <= tab_width_in;
         fill_char_ff <= fill_char_in;
      end
   end

   assign cfg.list_mode = list_mode_ff;
   assign cfg.tab_width = tab_width_ff;
   assign cfg.fill_char = fill_char_ff;

   tees_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tees_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   tees_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/tees_checker.sv =====
module tees_checker #(
   parameter int MAX_COLUMNS = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   localparam logic [10:0] MaxCount = 11'(MAX_COLUMNS);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Count and overflow only travel with the terminator
   a_mid_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[19:8] == 12'd0)
      else $error("count or overflow set before line end");

   // An overflowed line reports the saturated count
   a_overflow_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[19] |-> rsp_tdata[18:8] == MaxCount)
      else $error("overflow without saturated count");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'd0)
      else $error("pad bits set");

endmodule

bind tab_expand_escape_stream tees_checker #(
   .MAX_COLUMNS (MAX_COLUMNS)
) u_tees_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
